[src/gmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmc_pkg: shared types and constants for the gate motion controller
// Event codes, gate modes, stop causes, register map and reset values.
// ----------------------------------------------------------------------------
package gmc_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 7;
  localparam int unsigned AdcW    = 12;
  localparam int unsigned StepW   = 16;
  localparam int unsigned MotionW = 20;
  localparam int unsigned EnW     = 3;
  localparam int unsigned CauseW  = 3;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 20;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 16;

  localparam logic [PosW-1:0]    PosStep = 7'd5;
  localparam logic [PosW-1:0]    PosFull = 7'd100;
  localparam logic [PosW-1:0]    PosNearFull = 7'd95;
  localparam logic [StepW-1:0]   StepTimerMax = '1;
  localparam logic [MotionW-1:0] MotionTimerMax = '1;

  localparam logic [StepW-1:0]   StepPeriodRst  = 16'd300;
  localparam logic [MotionW-1:0] TimeoutRst     = 20'd30000;
  localparam logic [AdcW-1:0]    CurLimitRst    = 12'd3000;
  localparam logic [AdcW-1:0]    TempLimitRst   = 12'd3000;
  localparam logic [EnW-1:0]     EnablesRst     = 3'd7;

  // safety enable bits
  localparam int unsigned EnObstacle = 0;
  localparam int unsigned EnCurrent  = 1;
  localparam int unsigned EnTemp     = 2;

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 3'd0,
    OP_OPEN    = 3'd1,
    OP_CLOSE   = 3'd2,
    OP_STOP    = 3'd3,
    OP_PARTIAL = 3'd4
  } op_e;

  typedef enum logic [ModeW-1:0] {
    MODE_CLOSED  = 3'd0,
    MODE_OPENING = 3'd1,
    MODE_OPEN    = 3'd2,
    MODE_CLOSING = 3'd3,
    MODE_STOPPED = 3'd4
  } gate_mode_e;

  typedef enum logic [CauseW-1:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_TIMEOUT  = 3'd1,
    CAUSE_OBSTACLE = 3'd2,
    CAUSE_CURRENT  = 3'd3,
    CAUSE_TEMP     = 3'd4,
    CAUSE_END      = 3'd5
  } cause_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_STEP_PERIOD = 3'd0,
    REG_TIMEOUT     = 3'd1,
    REG_CUR_LIMIT   = 3'd2,
    REG_TEMP_LIMIT  = 3'd3,
    REG_ENABLES     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [StepW-1:0]   step_period;
    logic [MotionW-1:0] timeout;
    logic [AdcW-1:0]    cur_limit;
    logic [AdcW-1:0]    temp_limit;
    logic [EnW-1:0]     enables;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [PosW-1:0] target_percent;
    logic            obstacle_active;
    logic            limit_open_active;
    logic            limit_close_active;
    logic [AdcW-1:0] current_sample;
    logic [AdcW-1:0] temp_sample;
  } item_t;

  typedef struct packed {
    logic [ModeW-1:0]  gate_state;
    logic [PosW-1:0]   position_percent;
    logic              open_drive_on;
    logic              close_drive_on;
    logic              obstacle_flag;
    logic [CauseW-1:0] stop_cause;
  } result_t;

endpackage

[src/gate_motion_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_motion_controller_unit: motorised gate controller, top level
// Event stream in, gate status stream out, register write channel.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  s_axis   | in        | events: tuser op, tdata sensor fields
//  m_axis   | out       | one status transaction per event
//  cfg      | in        | register index and value, always ready
//
//  One event per cycle while the output is not stalled; each event passes the input
//  register, then the state update into the result register.
//  Reset clears the gate state and both valid flags and loads the register reset values.
//  A stalled result holds in the output register while the next event waits
//  in the input register; s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module gate_motion_controller_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: target_percent[6:0], obstacle_active[7], limit_open_active[8],
  //        limit_close_active[9], current_sample[21:10], temp_sample[33:22]
  input  logic [gmc_pkg::InDataW-1:0]        s_axis_tdata,
  // tuser: op[2:0]
  input  logic [gmc_pkg::InUserW-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: gate_state[2:0], position_percent[9:3], open_drive_on[10],
  //        close_drive_on[11], obstacle_flag[12], stop_cause[15:13]
  output logic [gmc_pkg::OutDataW-1:0]       m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gmc_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [gmc_pkg::CfgDataW-1:0]       cfg_data_i
);
  import gmc_pkg::*;

  cfg_t    cfg;
  item_t   item_q, item_d;
  result_t result;
  logic    in_valid_q, in_valid_d;
  logic    out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic    s_fire, advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.op                 = s_axis_tuser;
    item_d.target_percent     = s_axis_tdata[6:0];
    item_d.obstacle_active    = s_axis_tdata[7];
    item_d.limit_open_active  = s_axis_tdata[8];
    item_d.limit_close_active = s_axis_tdata[9];
    item_d.current_sample     = s_axis_tdata[21:10];
    item_d.temp_sample        = s_axis_tdata[33:22];
  end

  assign in_valid_d  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  assign out_data_d  = {result.stop_cause, result.obstacle_flag, result.close_drive_on,
                        result.open_drive_on, result.position_percent, result.gate_state};

  gmc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gmc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q <= item_d;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[src/gmc_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmc_cfg_regs: configuration register file
// Five registers written by index; the write channel never stalls.
// ----------------------------------------------------------------------------
module gmc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gmc_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [gmc_pkg::CfgDataW-1:0]   cfg_data_i,
  output gmc_pkg::cfg_t                  cfg_o
);
  import gmc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_STEP_PERIOD: cfg_d.step_period = cfg_data_i[StepW-1:0];
        REG_TIMEOUT:     cfg_d.timeout     = cfg_data_i[MotionW-1:0];
        REG_CUR_LIMIT:   cfg_d.cur_limit   = cfg_data_i[AdcW-1:0];
        REG_TEMP_LIMIT:  cfg_d.temp_limit  = cfg_data_i[AdcW-1:0];
        REG_ENABLES:     cfg_d.enables     = cfg_data_i[EnW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_period <= StepPeriodRst;
      cfg_q.timeout     <= TimeoutRst;
      cfg_q.cur_limit   <= CurLimitRst;
      cfg_q.temp_limit  <= TempLimitRst;
      cfg_q.enables     <= EnablesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[src/gmc_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmc_core: gate state and per-event update
// Holds mode, position, timers and obstacle flag; works out one event.
// ----------------------------------------------------------------------------
module gmc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  gmc_pkg::item_t   item_i,
  input  gmc_pkg::cfg_t    cfg_i,
  output gmc_pkg::result_t result_o
);
  import gmc_pkg::*;

  gate_mode_e         mode_q, mode_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               seen_q, seen_d;
  logic [StepW-1:0]   st_q, st_d;
  logic [MotionW-1:0] mt_q, mt_d;

  logic [StepW-1:0]   st_inc;
  logic [MotionW-1:0] mt_inc;
  logic [PosW-1:0]    tgt;
  logic [PosW-1:0]    pos_step;
  logic               moving;
  logic               end_hit;
  logic               req_open, req_close;
  cause_e             cause;

  assign moving = (mode_q == MODE_OPENING) || (mode_q == MODE_CLOSING);
  assign st_inc = (st_q != StepTimerMax) ? st_q + 1'b1 : st_q;
  assign mt_inc = (mt_q != MotionTimerMax) ? mt_q + 1'b1 : mt_q;
  assign tgt    = (item_i.target_percent > PosFull) ? PosFull : item_i.target_percent;

  // position after a step, toward the end of travel
  always_comb begin
    if (mode_q == MODE_OPENING) begin
      pos_step = (pos_q >= PosNearFull) ? PosFull : pos_q + PosStep;
      end_hit  = (pos_step == PosFull);
    end else begin
      pos_step = (pos_q <= PosStep) ? '0 : pos_q - PosStep;
      end_hit  = (pos_step == '0);
    end
  end

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    seen_d    = seen_q;
    st_d      = st_q;
    mt_d      = mt_q;
    cause     = CAUSE_NONE;
    req_open  = 1'b0;
    req_close = 1'b0;
    if (fire_i) begin
      unique case (item_i.op)
        OP_TICK: begin
          if (moving) begin
            st_d = st_inc;
            mt_d = mt_inc;
            if (st_inc >= cfg_i.step_period) begin
              st_d  = '0;
              pos_d = pos_step;
            end
            if ((st_inc >= cfg_i.step_period) && end_hit) begin
              mode_d = (mode_q == MODE_OPENING) ? MODE_OPEN : MODE_CLOSED;
              cause  = CAUSE_END;
            end else if (mt_inc > cfg_i.timeout) begin
              mode_d = MODE_STOPPED;
              cause  = CAUSE_TIMEOUT;
            end else if (cfg_i.enables[EnObstacle] && item_i.obstacle_active) begin
              seen_d = 1'b1;
              mode_d = MODE_STOPPED;
              cause  = CAUSE_OBSTACLE;
            end else begin
              seen_d = 1'b0;
              if (cfg_i.enables[EnCurrent] && (item_i.current_sample > cfg_i.cur_limit)) begin
                mode_d = MODE_STOPPED;
                cause  = CAUSE_CURRENT;
              end else if (cfg_i.enables[EnTemp] &&
                           (item_i.temp_sample > cfg_i.temp_limit)) begin
                mode_d = MODE_STOPPED;
                cause  = CAUSE_TEMP;
              end else if ((mode_q == MODE_OPENING) && item_i.limit_open_active) begin
                pos_d  = PosFull;
                mode_d = MODE_OPEN;
                cause  = CAUSE_END;
              end else if ((mode_q == MODE_CLOSING) && item_i.limit_close_active) begin
                pos_d  = '0;
                mode_d = MODE_CLOSED;
                cause  = CAUSE_END;
              end
            end
          end
        end
        OP_OPEN:    req_open  = 1'b1;
        OP_CLOSE:   req_close = 1'b1;
        OP_STOP:    mode_d    = MODE_STOPPED;
        OP_PARTIAL: begin
          req_open  = (tgt > pos_q);
          req_close = (tgt < pos_q);
        end
        default: mode_d = mode_q;
      endcase

      if (req_open && (mode_q != MODE_OPENING) && (pos_q != PosFull)) begin
        mode_d = MODE_OPENING;
        st_d   = '0;
        mt_d   = '0;
      end
      if (req_close && (mode_q != MODE_CLOSING) && (pos_q != '0)) begin
        mode_d = MODE_CLOSING;
        st_d   = '0;
        mt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CLOSED;
      pos_q  <= '0;
      seen_q <= 1'b0;
      st_q   <= '0;
      mt_q   <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      seen_q <= seen_d;
      st_q   <= st_d;
      mt_q   <= mt_d;
    end
  end

  assign result_o.gate_state       = mode_d;
  assign result_o.position_percent = pos_d;
  assign result_o.open_drive_on    = (mode_d == MODE_OPENING);
  assign result_o.close_drive_on   = (mode_d == MODE_CLOSING);
  assign result_o.obstacle_flag    = seen_d;
  assign result_o.stop_cause       = cause;

endmodule

[src/gmc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmc_checker: port-level checks for the gate motion controller
// Watches the status stream for consistency; bound to the top level.
// ----------------------------------------------------------------------------
module gmc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [gmc_pkg::OutDataW-1:0] m_axis_tdata
);
  import gmc_pkg::*;

  logic [ModeW-1:0]  st;
  logic [PosW-1:0]   pos;
  logic [CauseW-1:0] cause;

  assign st    = m_axis_tdata[2:0];
  assign pos   = m_axis_tdata[9:3];
  assign cause = m_axis_tdata[15:13];

  a_relays_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[10] && m_axis_tdata[11]))
    else $error("both relays driven");

  a_relay_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10] == (st == MODE_OPENING)) &&
                      (m_axis_tdata[11] == (st == MODE_CLOSING)))
    else $error("relay drive disagrees with gate state");

  a_position_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pos <= PosFull))
    else $error("position beyond full travel");

  a_cause_not_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (cause != CAUSE_NONE)) |->
      (st != MODE_OPENING) && (st != MODE_CLOSING))
    else $error("stop cause reported while still moving");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled status transaction changed");

endmodule

bind gate_motion_controller_unit gmc_checker u_gmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[bench/tb_gate_motion_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gate_motion_controller_unit: self-checking bench for the gate controller
// A directed table of events runs under the reset register values. Random
// event streams follow under several register settings, with random gaps
// on both streams. Every status transaction is checked field by field.
// ----------------------------------------------------------------------------
module tb_gate_motion_controller_unit;
  import gmc_pkg::*;

  localparam int unsigned ClkHalf       = 1;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned ReportCap     = 200;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned PhaseEvents   = 125;

  // codes the package leaves unnamed; the block ignores them
  localparam logic [OpW-1:0]      OpSpareFirst = 3'd5;
  localparam logic [OpW-1:0]      OpSpareLast  = 3'd7;
  localparam logic [CfgAddrW-1:0] RegSpare     = 3'd7;

  typedef struct {
    item_t   ev;
    bit      typed;
    result_t want;
  } event_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_ready_o;

  // gate model state and register copy
  cfg_t             shadow_cfg;
  gate_mode_e       sh_mode;
  logic [PosW-1:0]  sh_pos;
  logic             sh_obstacle;
  logic [StepW-1:0] sh_step_cnt;
  logic [MotionW-1:0] sh_run_cnt;

  result_t          expected_status_q[$];
  event_row_t       directed_rows[$];
  int unsigned      err_count   = 0;
  int unsigned      idle_cycles = 0;
  int               ready_hold  = 0;
  bit               steady_run  = 1'b0;

  always #ClkHalf clk_i = ~clk_i;

  gate_motion_controller_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  task automatic report_mismatch(string msg);
    if (err_count < ReportCap) $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // open or close request; ignored when already moving that way or at that end
  function automatic void begin_travel(gate_mode_e dir);
    if (dir == MODE_OPENING) begin
      if (sh_mode == MODE_OPENING || sh_pos == PosFull) return;
    end else begin
      if (sh_mode == MODE_CLOSING || sh_pos == '0) return;
    end
    sh_mode     = dir;
    sh_step_cnt = '0;
    sh_run_cnt  = '0;
  endfunction

  function automatic result_t predict_status(item_t ev);
    logic [PosW-1:0] tgt;
    cause_e          cause;
    bit              arrived;
    result_t         r;
    cause   = CAUSE_NONE;
    arrived = 1'b0;
    tgt     = (ev.target_percent > PosFull) ? PosFull : ev.target_percent;
    case (ev.op)
      OP_TICK: if (sh_mode == MODE_OPENING || sh_mode == MODE_CLOSING) begin
        if (sh_step_cnt != StepTimerMax) sh_step_cnt = sh_step_cnt + 1'b1;
        if (sh_run_cnt != MotionTimerMax) sh_run_cnt = sh_run_cnt + 1'b1;
        if (sh_step_cnt >= shadow_cfg.step_period) begin
          sh_step_cnt = '0;
          if (sh_mode == MODE_OPENING) begin
            sh_pos  = (sh_pos >= PosNearFull) ? PosFull : sh_pos + PosStep;
            arrived = (sh_pos == PosFull);
            if (arrived) sh_mode = MODE_OPEN;
          end else begin
            sh_pos  = (sh_pos <= PosStep) ? '0 : sh_pos - PosStep;
            arrived = (sh_pos == '0);
            if (arrived) sh_mode = MODE_CLOSED;
          end
          if (arrived) cause = CAUSE_END;
        end
        // safety checks only when the step did not end the travel
        if (!arrived) begin
          if (sh_run_cnt > shadow_cfg.timeout) begin
            sh_mode = MODE_STOPPED;
            cause   = CAUSE_TIMEOUT;
          end else if (shadow_cfg.enables[EnObstacle] && ev.obstacle_active) begin
            sh_obstacle = 1'b1;
            sh_mode     = MODE_STOPPED;
            cause       = CAUSE_OBSTACLE;
          end else begin
            sh_obstacle = 1'b0;
            if (shadow_cfg.enables[EnCurrent] && ev.current_sample > shadow_cfg.cur_limit) begin
              sh_mode = MODE_STOPPED;
              cause   = CAUSE_CURRENT;
            end else if (shadow_cfg.enables[EnTemp] &&
                         ev.temp_sample > shadow_cfg.temp_limit) begin
              sh_mode = MODE_STOPPED;
              cause   = CAUSE_TEMP;
            end else if (sh_mode == MODE_OPENING && ev.limit_open_active) begin
              sh_pos  = PosFull;
              sh_mode = MODE_OPEN;
              cause   = CAUSE_END;
            end else if (sh_mode == MODE_CLOSING && ev.limit_close_active) begin
              sh_pos  = '0;
              sh_mode = MODE_CLOSED;
              cause   = CAUSE_END;
            end
          end
        end
      end
      OP_OPEN:  begin_travel(MODE_OPENING);
      OP_CLOSE: begin_travel(MODE_CLOSING);
      OP_STOP:  sh_mode = MODE_STOPPED;
      OP_PARTIAL: begin
        if (tgt > sh_pos) begin_travel(MODE_OPENING);
        else if (tgt < sh_pos) begin_travel(MODE_CLOSING);
      end
      default: ;
    endcase
    r.gate_state       = sh_mode;
    r.position_percent = sh_pos;
    r.open_drive_on    = (sh_mode == MODE_OPENING);
    r.close_drive_on   = (sh_mode == MODE_CLOSING);
    r.obstacle_flag    = sh_obstacle;
    r.stop_cause       = cause;
    return r;
  endfunction

  task automatic add_row(logic [OpW-1:0] op, logic [PosW-1:0] tgt, logic obs, logic lim_o,
                         logic lim_c, logic [AdcW-1:0] cur, logic [AdcW-1:0] temp, bit typed,
                         gate_mode_e st, logic [PosW-1:0] pos, logic oflag, cause_e cause);
    event_row_t row;
    row.ev.op                 = op;
    row.ev.target_percent     = tgt;
    row.ev.obstacle_active    = obs;
    row.ev.limit_open_active  = lim_o;
    row.ev.limit_close_active = lim_c;
    row.ev.current_sample     = cur;
    row.ev.temp_sample        = temp;
    row.typed                 = typed;
    row.want.gate_state       = st;
    row.want.position_percent = pos;
    row.want.open_drive_on    = (st == MODE_OPENING);
    row.want.close_drive_on   = (st == MODE_CLOSING);
    row.want.obstacle_flag    = oflag;
    row.want.stop_cause       = cause;
    directed_rows.push_back(row);
  endtask

  // tvalid is only lowered ahead of a gap, so back-to-back events keep it high
  task automatic send_event(item_t ev, bit typed, result_t want);
    int unsigned gap;
    result_t     calc;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.op;
    s_axis_tdata  <= {6'b0, ev.temp_sample, ev.current_sample, ev.limit_close_active,
                      ev.limit_open_active, ev.obstacle_active, ev.target_percent};
    do @(posedge clk_i); while (!s_axis_tready);
    calc = predict_status(ev);
    expected_status_q.push_back(typed ? want : calc);
  endtask

  // leaves cfg_valid_i high; the caller lowers it after the last write
  task automatic write_register(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_STEP_PERIOD: shadow_cfg.step_period = val[StepW-1:0];
      REG_TIMEOUT:     shadow_cfg.timeout     = val[MotionW-1:0];
      REG_CUR_LIMIT:   shadow_cfg.cur_limit   = val[AdcW-1:0];
      REG_TEMP_LIMIT:  shadow_cfg.temp_limit  = val[AdcW-1:0];
      REG_ENABLES:     shadow_cfg.enables     = val[EnW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_status();
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : status_sink
    result_t             want;
    logic [OutDataW-1:0] got;
    if (ready_hold <= 0) begin
      if (steady_run) begin
        m_axis_tready <= 1'b1;
        ready_hold = 16;
      end else if ($urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        ready_hold = $urandom_range(1, 8);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold = pick_gap() + 1;
      end
    end
    ready_hold--;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_status_q.size() == 0) begin
        report_mismatch($sformatf("status %h with nothing outstanding", got));
      end else begin
        want = expected_status_q.pop_front();
        if (got[2:0] !== want.gate_state)
          report_mismatch($sformatf("gate_state %0d, want %0d", got[2:0], want.gate_state));
        if (got[9:3] !== want.position_percent)
          report_mismatch($sformatf("position %0d, want %0d", got[9:3],
                                    want.position_percent));
        if (got[10] !== want.open_drive_on)
          report_mismatch($sformatf("open_drive %b, want %b", got[10], want.open_drive_on));
        if (got[11] !== want.close_drive_on)
          report_mismatch($sformatf("close_drive %b, want %b", got[11],
                                    want.close_drive_on));
        if (got[12] !== want.obstacle_flag)
          report_mismatch($sformatf("obstacle_flag %b, want %b", got[12], want.obstacle_flag));
        if (got[15:13] !== want.stop_cause)
          report_mismatch($sformatf("stop_cause %0d, want %0d", got[15:13], want.stop_cause));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    item_t             ev;
    result_t           blank;
    int unsigned       r;
    logic [StepW-1:0]  step_v;
    logic [MotionW-1:0] tmo_v;
    logic [AdcW-1:0]   cur_v;
    logic [AdcW-1:0]   temp_v;
    logic [EnW-1:0]    en_v;

    shadow_cfg.step_period = StepPeriodRst;
    shadow_cfg.timeout     = TimeoutRst;
    shadow_cfg.cur_limit   = CurLimitRst;
    shadow_cfg.temp_limit  = TempLimitRst;
    shadow_cfg.enables     = EnablesRst;
    sh_mode     = MODE_CLOSED;
    sh_pos      = '0;
    sh_obstacle = 1'b0;
    sh_step_cnt = '0;
    sh_run_cnt  = '0;
    blank       = '0;

    // reset register values throughout; typed rows follow the state by hand
    add_row(OP_TICK, 7'd127, 1'b1, 1'b1, 1'b1, 12'hFFF, 12'hFFF, 1'b1, MODE_CLOSED, 7'd0,
            1'b0, CAUSE_NONE);
    add_row(OP_TICK, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b0, MODE_CLOSED, 7'd0,
            1'b0, CAUSE_NONE);
    add_row(OP_CLOSE, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_CLOSED, 7'd0,
            1'b0, CAUSE_NONE);
    add_row(OP_PARTIAL, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_CLOSED, 7'd0,
            1'b0, CAUSE_NONE);
    add_row(OP_STOP, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_STOPPED, 7'd0,
            1'b0, CAUSE_NONE);
    add_row(OpSpareFirst, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_STOPPED,
            7'd0, 1'b0, CAUSE_NONE);
    add_row(OpSpareLast, 7'd127, 1'b1, 1'b1, 1'b1, 12'hFFF, 12'hFFF, 1'b1, MODE_STOPPED,
            7'd0, 1'b0, CAUSE_NONE);
    add_row(OP_OPEN, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_OPENING, 7'd0,
            1'b0, CAUSE_NONE);
    add_row(OP_OPEN, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_OPENING, 7'd0,
            1'b0, CAUSE_NONE);
    // obstacle outranks the overcurrent that comes with it
    add_row(OP_TICK, 7'd0, 1'b1, 1'b0, 1'b0, 12'hFFF, 12'h000, 1'b1, MODE_STOPPED, 7'd0,
            1'b1, CAUSE_OBSTACLE);
    add_row(OP_PARTIAL, 7'd127, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_OPENING,
            7'd0, 1'b1, CAUSE_NONE);
    add_row(OP_TICK, 7'd0, 1'b0, 1'b0, 1'b0, CurLimitRst + 1'b1, 12'hFFF, 1'b1,
            MODE_STOPPED, 7'd0, 1'b0, CAUSE_CURRENT);
    add_row(OP_CLOSE, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_STOPPED, 7'd0,
            1'b0, CAUSE_NONE);
    add_row(OP_OPEN, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_OPENING, 7'd0,
            1'b0, CAUSE_NONE);
    add_row(OP_TICK, 7'd0, 1'b0, 1'b0, 1'b0, CurLimitRst, TempLimitRst + 1'b1, 1'b1,
            MODE_STOPPED, 7'd0, 1'b0, CAUSE_TEMP);
    add_row(OP_OPEN, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_OPENING, 7'd0,
            1'b0, CAUSE_NONE);
    add_row(OP_TICK, 7'd0, 1'b0, 1'b0, 1'b1, 12'h000, TempLimitRst, 1'b0, MODE_CLOSED,
            7'd0, 1'b0, CAUSE_NONE);
    add_row(OP_TICK, 7'd0, 1'b0, 1'b1, 1'b0, 12'h000, 12'h000, 1'b1, MODE_OPEN, 7'd100,
            1'b0, CAUSE_END);
    add_row(OP_OPEN, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_OPEN, 7'd100,
            1'b0, CAUSE_NONE);
    add_row(OP_PARTIAL, 7'd100, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_OPEN,
            7'd100, 1'b0, CAUSE_NONE);
    // targets above full travel clamp to it
    add_row(OP_PARTIAL, 7'd101, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_OPEN,
            7'd100, 1'b0, CAUSE_NONE);
    add_row(OP_PARTIAL, 7'd50, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_CLOSING,
            7'd100, 1'b0, CAUSE_NONE);
    add_row(OP_CLOSE, 7'd0, 1'b0, 1'b0, 1'b0, 12'h000, 12'h000, 1'b1, MODE_CLOSING,
            7'd100, 1'b0, CAUSE_NONE);
    add_row(OP_TICK, 7'd0, 1'b0, 1'b1, 1'b0, 12'h000, 12'h000, 1'b0, MODE_CLOSED, 7'd0,
            1'b0, CAUSE_NONE);
    add_row(OP_TICK, 7'd0, 1'b0, 1'b0, 1'b1, 12'h000, 12'h000, 1'b1, MODE_CLOSED, 7'd0,
            1'b0, CAUSE_END);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_event(directed_rows[i].ev, directed_rows[i].typed,
                                          directed_rows[i].want);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      s_axis_tvalid <= 1'b0;
      drain_status();
      case (phase)
        0: begin
          // zero step period: a step on every tick; all checks off
          step_v = '0; tmo_v = MotionTimerMax; cur_v = '1; temp_v = '1; en_v = '0;
        end
        1: begin
          step_v = 16'd1; tmo_v = '0; cur_v = '0; temp_v = '0; en_v = '1;
        end
        2: begin
          step_v = '1; tmo_v = MotionTimerMax; cur_v = CurLimitRst; temp_v = TempLimitRst;
          en_v = EnablesRst;
        end
        default: begin
          step_v = 16'($urandom_range(1, 4));
          tmo_v  = 20'($urandom_range(5, 120));
          cur_v  = 12'($urandom_range(0, 4095));
          temp_v = 12'($urandom_range(0, 4095));
          en_v   = 3'($urandom_range(0, 7));
        end
      endcase
      // unused upper data bits carry noise, the block keeps only the register width
      write_register(REG_STEP_PERIOD, {4'($urandom), step_v});
      write_register(REG_TIMEOUT, tmo_v);
      write_register(REG_CUR_LIMIT, {8'($urandom), cur_v});
      write_register(REG_TEMP_LIMIT, {8'($urandom), temp_v});
      write_register(REG_ENABLES, {17'($urandom), en_v});
      if (phase == 0) write_register(RegSpare, '1);
      cfg_valid_i <= 1'b0;
      steady_run = (phase == 2 || phase == 5);

      repeat (PhaseEvents) begin
        r = $urandom_range(0, 99);
        if (r < 88) ev.op = OP_TICK;
        else if (r < 92) ev.op = OP_OPEN;
        else if (r < 95) ev.op = OP_CLOSE;
        else if (r < 96) ev.op = OP_STOP;
        else if (r < 99) ev.op = OP_PARTIAL;
        else ev.op = 3'(OpSpareFirst + $urandom_range(0, 2));
        ev.target_percent     = 7'($urandom_range(0, 127));
        ev.obstacle_active    = ($urandom_range(0, 39) == 0);
        ev.limit_open_active  = ($urandom_range(0, 39) == 0);
        ev.limit_close_active = ($urandom_range(0, 39) == 0);
        ev.current_sample     = ($urandom_range(0, 29) == 0) ? 12'($urandom) :
                                12'($urandom_range(0, shadow_cfg.cur_limit));
        ev.temp_sample        = ($urandom_range(0, 29) == 0) ? 12'($urandom) :
                                12'($urandom_range(0, shadow_cfg.temp_limit));
        send_event(ev, 1'b0, blank);
      end
    end

    s_axis_tvalid <= 1'b0;
    steady_run = 1'b0;
    drain_status();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
